/* src/wbs_pkg.sv */
// ----------------------------------------------------------------------------
// wbs_pkg
// shared types, constants and pattern element helpers for the signature scan
// ----------------------------------------------------------------------------
package wbs_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int OFFSET_BITS = 32;

    localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CMP_W = (OFFSET_BITS > 32) ? OFFSET_BITS : 32;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_LO = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BYTES_HI = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KINDS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LENGTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START    = 3'd4;

    typedef enum logic [1:0] {
        K_SPECIFIC = 2'd0,
        K_ANY      = 2'd1,
        K_OPTIONAL = 2'd2,
        K_ACCEPT   = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } t_in_word;

    typedef struct packed {
        logic        found;
        logic [31:0] match_offset;
    } t_out_word;

    typedef struct packed {
        logic start;
    } t_scan_ctl;

    typedef struct packed {
        logic busy;
        logic done;
        logic hit;
    } t_scan_sts;

    // elements past sixteen are specific bytes of value zero
    function automatic t_kind elem_kind(input int e, input logic [31:0] kinds);
        t_kind k;
        k = K_SPECIFIC;
        if (e < 16) begin
            k = t_kind'(kinds[2*e +: 2]);
        end
        return k;
    endfunction

    function automatic logic [7:0] elem_byte(input int e, input logic [63:0] lo,
                                             input logic [63:0] hi);
        logic [7:0] b;
        b = 8'd0;
        if (e < 8) begin
            b = lo[8*e +: 8];
        end else if (e < 16) begin
            b = hi[8*(e-8) +: 8];
        end
        return b;
    endfunction

    // length zero acts as one, above the window acts as the window size
    function automatic logic [LEN_W-1:0] used_len(input logic [4:0] r);
        logic [LEN_W-1:0] n;
        if (r == 5'd0) begin
            n = LEN_W'(1);
        end else if (int'(r) > MAX_PATTERN) begin
            n = LEN_W'(MAX_PATTERN);
        end else begin
            n = LEN_W'(r);
        end
        return n;
    endfunction

endpackage

/* src/wbs_window.sv */
// ----------------------------------------------------------------------------
// wbs_window
// byte window shift line with a compare of one pattern byte against all taps
// ----------------------------------------------------------------------------
module wbs_window
    import wbs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_shift,
    input  logic [7:0]             i_byte,
    input  logic                   i_clear,
    input  logic [7:0]             i_cmp_byte,
    output logic [MAX_PATTERN-1:0] o_eq
);

    logic [7:0] r_win [MAX_PATTERN];

    // oldest byte at tap 0, newest at the top tap
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            for (int j = 0; j < MAX_PATTERN; j++) begin
                r_win[j] <= 8'd0;
            end
        end else if (i_shift) begin
            for (int j = 0; j < MAX_PATTERN - 1; j++) begin
                r_win[j] <= r_win[j+1];
            end
            r_win[MAX_PATTERN-1] <= i_byte;
        end
    end

    always_comb begin
        for (int j = 0; j < MAX_PATTERN; j++) begin
            o_eq[j] = (r_win[j] == i_cmp_byte);
        end
    end

endmodule

/* src/wbs_matcher.sv */
// ----------------------------------------------------------------------------
// wbs_matcher
// walks the pattern one element per cycle over the set of reachable taps
// ----------------------------------------------------------------------------
module wbs_matcher
    import wbs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_scan_ctl              i_ctl,
    input  logic [LEN_W-1:0]       i_len,
    input  logic [63:0]            i_bytes_lo,
    input  logic [63:0]            i_bytes_hi,
    input  logic [31:0]            i_kinds,
    input  logic [MAX_PATTERN-1:0] i_eq,
    output logic [7:0]             o_cmp_byte,
    output t_scan_sts              o_sts
);

    logic                   r_busy;
    logic [IDX_W-1:0]       r_elem;
    logic [MAX_PATTERN-1:0] r_reach;

    t_kind                  kind;
    logic                   is_last;
    logic                   hit;
    logic                   finish;
    logic [MAX_PATTERN-1:0] n_reach;
    logic [IDX_W-1:0]       start_tap;

    assign kind       = elem_kind(int'(r_elem), i_kinds);
    assign o_cmp_byte = elem_byte(int'(r_elem), i_bytes_lo, i_bytes_hi);
    assign is_last    = ((LEN_W'(r_elem) + LEN_W'(1)) == i_len);
    assign start_tap  = IDX_W'(MAX_PATTERN - int'(i_len));

    // reach bits are window taps; a bit shifts up as the element takes a byte
    always_comb begin
        if (is_last) begin
            hit = (kind != K_SPECIFIC) ? (|r_reach) : (|(r_reach & i_eq));
        end else begin
            hit = (kind == K_ACCEPT) && (|r_reach);
        end
        case (kind)
            K_SPECIFIC: n_reach = (r_reach & i_eq) << 1;
            K_ANY:      n_reach = r_reach << 1;
            K_OPTIONAL: n_reach = r_reach | (r_reach << 1);
            default:    n_reach = '0;
        endcase
        finish = hit || is_last || (n_reach == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_ctl.start) begin
            r_busy <= 1'b1;
        end else if (r_busy && finish) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_elem  <= '0;
            r_reach <= MAX_PATTERN'(1) << start_tap;
        end else if (r_busy) begin
            r_elem  <= r_elem + IDX_W'(1);
            r_reach <= n_reach;
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_busy && finish;
    assign o_sts.hit  = r_busy && finish && hit;

endmodule

/* src/wildcard_byte_signature_scan.sv */
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan
// first-match scan of a byte region against a wildcard signature
// ----------------------------------------------------------------------------
// each region byte is taken as one word; once enough bytes for the pattern
// are held and the candidate start lies at or after start_offset, the pattern
// is walked over the window one element per cycle by a single compare unit,
// with optional elements tracked as a set of live window taps so no
// backtracking pass is needed. a byte goes through check and emit states,
// with a scan state between them when a start is tried; the walk stops at
// the last element in use (at most 16), or early on a hit, an accept-rest
// element or no live tap. the input is not ready while a byte is in work.
// the first match gives one word with found set and the start offset; a
// region without a match gives one not-found word on its last byte; bytes
// after a match give nothing. the result sits in an output register, so the
// next byte can be taken while it waits. the config port is always ready and
// must be written by the user while the block is idle (not enforced here).
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scan
    import wbs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // byte stream
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_word             i_in_word,
    // result
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_word            o_out_word,
    // config writes
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [63:0]          i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CHECK,
        S_SCAN,
        S_EMIT
    } t_state;

    // config registers
    logic [63:0] r_bytes_lo;
    logic [63:0] r_bytes_hi;
    logic [31:0] r_kinds;
    logic [4:0]  r_length;
    logic [31:0] r_start;

    // control state and registered outputs
    t_state                 r_state,     n_state;
    logic [OFFSET_BITS-1:0] r_pos,       n_pos;
    logic [LEN_W-1:0]       r_fill,      n_fill;
    logic                   r_reported,  n_reported;
    logic                   r_last,      n_last;
    logic                   r_hit,       n_hit;
    logic [OFFSET_BITS-1:0] r_cand_off,  n_cand_off;
    logic                   r_out_valid, n_out_valid;
    t_out_word              r_out_word,  n_out_word;

    logic                   in_accept;
    logic [LEN_W-1:0]       len;
    logic [OFFSET_BITS-1:0] cand_off;
    logic                   eligible;
    logic                   have_result;
    logic                   slot_free;
    logic                   win_clear;
    logic [7:0]             cmp_byte;
    logic [MAX_PATTERN-1:0] eq;
    t_scan_ctl              scan_ctl;
    t_scan_sts              scan_sts;

    assign in_accept   = i_in_valid && o_in_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    assign len = used_len(r_length);

    // candidate start for the byte just shifted in, wraps with the position
    assign cand_off = r_pos - (OFFSET_BITS'(len) - OFFSET_BITS'(1));
    assign eligible = !r_reported && (r_fill >= len) &&
                      (CMP_W'(cand_off) >= CMP_W'(r_start));

    assign have_result = r_hit || (r_last && !r_reported);
    assign slot_free   = !r_out_valid || i_out_ready;

    // config write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_lo <= '0;
            r_bytes_hi <= '0;
            r_kinds    <= '0;
            r_length   <= 5'd1;
            r_start    <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BYTES_LO: r_bytes_lo <= i_cfg_data;
                CFG_BYTES_HI: r_bytes_hi <= i_cfg_data;
                CFG_KINDS:    r_kinds    <= i_cfg_data[31:0];
                CFG_LENGTH:   r_length   <= i_cfg_data[4:0];
                CFG_START:    r_start    <= i_cfg_data[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        n_state     = r_state;
        n_pos       = r_pos;
        n_fill      = r_fill;
        n_reported  = r_reported;
        n_last      = r_last;
        n_hit       = r_hit;
        n_cand_off  = r_cand_off;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_word  = r_out_word;
        scan_ctl    = '0;
        win_clear   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    // window shifts on this edge, fill saturates at the window size
                    n_last = i_in_word.last_byte;
                    n_hit  = 1'b0;
                    if (r_fill != LEN_W'(MAX_PATTERN)) begin
                        n_fill = r_fill + LEN_W'(1);
                    end
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                n_cand_off = cand_off;
                if (eligible) begin
                    scan_ctl.start = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_SCAN: begin
                if (scan_sts.done) begin
                    n_hit   = scan_sts.hit;
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                // hold here while an earlier result still waits
                if (!have_result || slot_free) begin
                    if (have_result) begin
                        n_out_valid             = 1'b1;
                        n_out_word.found        = r_hit;
                        n_out_word.match_offset = r_hit ? 32'(CMP_W'(r_cand_off)) : 32'd0;
                    end
                    if (r_last) begin
                        // end of region: back to a fresh window
                        win_clear  = 1'b1;
                        n_pos      = '0;
                        n_fill     = '0;
                        n_reported = 1'b0;
                    end else begin
                        n_pos      = r_pos + OFFSET_BITS'(1);
                        n_reported = r_reported || r_hit;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pos       <= '0;
            r_fill      <= '0;
            r_reported  <= 1'b0;
            r_last      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pos       <= n_pos;
            r_fill      <= n_fill;
            r_reported  <= n_reported;
            r_last      <= n_last;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
        r_cand_off <= n_cand_off;
        r_out_word <= n_out_word;
    end

    wbs_window u_window (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_shift    (in_accept),
        .i_byte     (i_in_word.data_byte),
        .i_clear    (win_clear),
        .i_cmp_byte (cmp_byte),
        .o_eq       (eq)
    );

    wbs_matcher u_matcher (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (scan_ctl),
        .i_len      (len),
        .i_bytes_lo (r_bytes_lo),
        .i_bytes_hi (r_bytes_hi),
        .i_kinds    (r_kinds),
        .i_eq       (eq),
        .o_cmp_byte (cmp_byte),
        .o_sts      (scan_sts)
    );

`ifndef SYNTHESIS
    // the shared compare unit only runs while the sequencer waits on it
    a_scan_in_scan_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        scan_sts.busy |-> (r_state == S_SCAN))
        else $error("matcher busy outside of scan state");

    // a not-found word always carries a zero offset
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_word.found) |-> (r_out_word.match_offset == 32'd0))
        else $error("not-found word with nonzero offset");

    // no second match word within one region
    a_single_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CHECK && r_reported) |=> (r_state == S_EMIT))
        else $error("scan started after a match was reported");

    // fill count never passes the window size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= LEN_W'(MAX_PATTERN))
        else $error("window fill count out of range");
`endif

endmodule

/* sim/wildcard_byte_signature_scan_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wildcard_byte_signature_scan_tb
// self-checking bench for the wildcard byte signature scan
// ----------------------------------------------------------------------------
// a short directed table runs first, then random regions over many pattern
// settings; every accepted byte word is run through a local scan predictor
// and the result words of the block are checked in order against it, or against the directed row's word. both
// data channels idle at random, and once the result side holds off long
// enough for the block to back up into its input.
// ----------------------------------------------------------------------------
module wildcard_byte_signature_scan_tb;
    import wbs_pkg::*;

    localparam int IDLE_PCT     = 21;
    localparam int HOLD_CYCLES  = 400;     // long result-side hold-off
    localparam int SETTLE       = 40;      // covers the slowest byte
    localparam int RAND_ITEMS   = 880;
    localparam int PHASE_ITEMS  = 70;
    localparam int DRAIN_LIMIT  = 5000;

    // rows of the directed table
    typedef enum logic [1:0] {
        ROW_CFG,        // load a new pattern setting
        ROW_PREDICT,    // byte checked against the predictor
        ROW_NONE,       // byte that must give no word
        ROW_ONE         // byte whose word is typed in the row
    } t_row_kind;

    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  data;
        logic        is_last;
        t_out_word   res;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [31:0] kinds;
        logic [4:0]  len;
        logic [31:0] start;
    } t_row;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    t_in_word             in_word;
    logic                 out_valid;
    logic                 out_ready;
    t_out_word            out_word;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [63:0]          cfg_data;

    // tag that travels with the byte word on offer
    t_row_kind            row_tag;
    t_out_word            row_res;

    // idling control
    logic                 calm;
    int                   hold_ask;
    int                   hold_seen;

    int                   err_count;
    t_out_word            want_words[$];
    t_row                 plan[$];
    logic [7:0]           region_q[$];

    // predictor copy of the registers
    logic [63:0]          m_lo    = '0;
    logic [63:0]          m_hi    = '0;
    logic [31:0]          m_kinds = '0;
    logic [4:0]           m_len   = 5'd1;
    logic [31:0]          m_start = '0;

    // predictor scan state
    logic [7:0]           win [MAX_PATTERN];
    logic [31:0]          pos      = '0;
    bit                   reported = 1'b0;
    int                   fill     = 0;

    // stimulus copy of the current pattern, used to plant matches
    logic [63:0]          p_lo;
    logic [63:0]          p_hi;
    logic [31:0]          p_kinds;

    wildcard_byte_signature_scan dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial begin
        foreach (win[i]) win[i] = 8'd0;
        err_count = 0;
        hold_seen = 0;
    end

    task automatic report_mismatch(input string msg);
        err_count++;
        $display("mismatch at %0t: %s", $realtime, msg);
    endtask

    // ------------------------------------------------------------------
    // scan predictor
    // ------------------------------------------------------------------

    // zero acts as one, anything past the window acts as the window
    function automatic int active_len(input logic [4:0] r);
        int n;
        n = int'(r);
        if (n == 0) begin
            n = 1;
        end else if (n > MAX_PATTERN) begin
            n = MAX_PATTERN;
        end
        return n;
    endfunction

    // walks the pattern over the newest len window bytes; the optional
    // element is followed as a set of live byte taps instead of backtracking
    function automatic bit pattern_hits(input int len);
        logic [17:0] live;
        logic [17:0] step_set;
        t_kind       k;
        logic [7:0]  pb;
        int          e;
        int          a;
        live = 18'd1;
        for (e = 0; e < len; e++) begin
            live &= ~({18{1'b1}} << len);
            if (live == '0) begin
                return 1'b0;
            end
            k  = t_kind'(m_kinds[2*e +: 2]);
            pb = (e < 8) ? m_lo[8*e +: 8] : m_hi[8*(e-8) +: 8];
            // last element: only a specific byte has to be there
            if (e == len - 1) begin
                if (k != K_SPECIFIC) begin
                    return 1'b1;
                end
                for (a = 0; a < len; a++) begin
                    if (live[a] && win[MAX_PATTERN-len+a] == pb) begin
                        return 1'b1;
                    end
                end
                return 1'b0;
            end
            step_set = '0;
            case (k)
                K_ACCEPT: begin
                    return 1'b1;
                end
                K_ANY: begin
                    step_set = live << 1;
                end
                K_OPTIONAL: begin
                    step_set = live | (live << 1);
                end
                default: begin
                    for (a = 0; a < len; a++) begin
                        if (live[a] && win[MAX_PATTERN-len+a] == pb) begin
                            step_set[a+1] = 1'b1;
                        end
                    end
                end
            endcase
            live = step_set;
        end
        return 1'b0;
    endfunction

    task automatic scan_byte(input logic [7:0] b, input logic is_last,
                             output bit hit, output t_out_word res);
        int          len;
        int          i;
        logic [31:0] cand;
        len = active_len(m_len);
        hit = 1'b0;
        res = '0;
        for (i = 0; i < MAX_PATTERN - 1; i++) begin
            win[i] = win[i+1];
        end
        win[MAX_PATTERN-1] = b;
        if (fill < MAX_PATTERN) begin
            fill++;
        end
        if (!reported && fill >= len) begin
            cand = pos - 32'(len - 1);
            if (cand >= m_start && pattern_hits(len)) begin
                hit              = 1'b1;
                res.found        = 1'b1;
                res.match_offset = cand;
                reported         = 1'b1;
            end
        end
        if (is_last) begin
            // region over: not found unless a match came already
            if (!hit && !reported) begin
                hit = 1'b1;
                res = '0;
            end
            foreach (win[j]) win[j] = 8'd0;
            fill     = 0;
            pos      = '0;
            reported = 1'b0;
        end else begin
            pos = pos + 32'd1;
        end
    endtask

    task automatic apply_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] d);
        case (idx)
            CFG_BYTES_LO: m_lo    = d;
            CFG_BYTES_HI: m_hi    = d;
            CFG_KINDS:    m_kinds = d[31:0];
            CFG_LENGTH:   m_len   = d[4:0];
            CFG_START:    m_start = d[31:0];
            default: ;
        endcase
    endtask

    // ------------------------------------------------------------------
    // scoreboard: results first, then config and bytes taken this edge
    // ------------------------------------------------------------------
    always @(posedge clk) begin : scoreboard
        t_out_word want;
        t_out_word got;
        bit        hit;
        if (rst_n) begin
            if (out_valid && out_ready) begin
                if (want_words.size() == 0) begin
                    report_mismatch($sformatf("word with none pending: found=%0b offset=%08h",
                                              out_word.found, out_word.match_offset));
                end else begin
                    want = want_words.pop_front();
                    if (out_word.found !== want.found) begin
                        report_mismatch($sformatf("found %0b, wanted %0b",
                                                  out_word.found, want.found));
                    end
                    if (out_word.match_offset !== want.match_offset) begin
                        report_mismatch($sformatf("match_offset %08h, wanted %08h",
                                                  out_word.match_offset, want.match_offset));
                    end
                end
            end
            if (cfg_valid && cfg_ready) begin
                apply_cfg(cfg_index, cfg_data);
            end
            if (in_valid && in_ready) begin
                scan_byte(in_word.data_byte, in_word.last_byte, hit, got);
                case (row_tag)
                    ROW_ONE:  want_words.push_back(row_res);
                    ROW_NONE: ;
                    default: begin
                        if (hit) begin
                            want_words.push_back(got);
                        end
                    end
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // result side: random idling, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin : result_side
        int n;
        out_ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (hold_ask != hold_seen) begin
                hold_seen = hold_ask;
                out_ready <= 1'b0;
                // counted here so the byte side keeps offering meanwhile
                for (n = 0; n < HOLD_CYCLES; n++) begin
                    @(posedge clk);
                end
            end else begin
                out_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // offer one byte word; valid stays high into the next word unless idling
    task automatic offer_byte(input logic [7:0] b, input logic is_last,
                              input t_row_kind tag, input t_out_word res);
        t_in_word w;
        w.data_byte = b;
        w.last_byte = is_last;
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        row_tag  <= tag;
        row_res  <= res;
        do @(posedge clk); while (!in_ready);
    endtask

    // block idle: nothing pending and the last byte long done
    task automatic settle();
        in_valid <= 1'b0;
        while (want_words.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic load_pattern(input logic [63:0] lo, input logic [63:0] hi,
                                input logic [31:0] kinds, input logic [4:0] len,
                                input logic [31:0] start);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [63:0]          val [5];
        int                   r;
        idx[0] = CFG_BYTES_LO; val[0] = lo;
        idx[1] = CFG_BYTES_HI; val[1] = hi;
        idx[2] = CFG_KINDS;    val[2] = 64'(kinds);
        idx[3] = CFG_LENGTH;   val[3] = 64'(len);
        idx[4] = CFG_START;    val[4] = 64'(start);
        for (r = 0; r < 5; r++) begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[r];
            cfg_data  <= val[r];
            do @(posedge clk); while (!cfg_ready);
        end
        cfg_valid <= 1'b0;
        p_lo    = lo;
        p_hi    = hi;
        p_kinds = kinds;
    endtask

    function automatic void add_cfg(input logic [63:0] lo, input logic [63:0] hi,
                                    input logic [31:0] kinds, input logic [4:0] len,
                                    input logic [31:0] start);
        t_row r;
        r       = '0;
        r.kind  = ROW_CFG;
        r.lo    = lo;
        r.hi    = hi;
        r.kinds = kinds;
        r.len   = len;
        r.start = start;
        plan.push_back(r);
    endfunction

    function automatic void add_byte(input t_row_kind kind, input logic [7:0] b,
                                     input logic is_last, input logic found,
                                     input logic [31:0] offset);
        t_row r;
        r                  = '0;
        r.kind             = kind;
        r.data             = b;
        r.is_last          = is_last;
        r.res.found        = found;
        r.res.match_offset = offset;
        plan.push_back(r);
    endfunction

    // half the bytes come from the pattern itself so matches are common
    function automatic logic [7:0] pick_byte(input int len);
        int         e;
        logic [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(0, 1) == 1) begin
            e = $urandom_range(0, len - 1);
            b = (e < 8) ? p_lo[8*e +: 8] : p_hi[8*(e-8) +: 8];
        end
        return b;
    endfunction

    function automatic logic [31:0] random_kinds();
        logic [31:0] k;
        int          e;
        int          roll;
        for (e = 0; e < 16; e++) begin
            roll = $urandom_range(0, 99);
            if (roll < 60) begin
                k[2*e +: 2] = K_SPECIFIC;
            end else if (roll < 75) begin
                k[2*e +: 2] = K_ANY;
            end else if (roll < 93) begin
                k[2*e +: 2] = K_OPTIONAL;
            end else begin
                k[2*e +: 2] = K_ACCEPT;
            end
        end
        return k;
    endfunction

    // mostly short patterns, a few full-window and out-of-range lengths
    function automatic logic [4:0] random_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40) begin
            return 5'($urandom_range(1, 4));
        end else if (roll < 70) begin
            return 5'($urandom_range(5, 8));
        end else if (roll < 85) begin
            return 5'($urandom_range(9, 15));
        end else if (roll < 95) begin
            return 5'd16;
        end else if (roll < 97) begin
            return 5'd0;
        end
        return 5'($urandom_range(17, 31));
    endfunction

    function automatic logic [31:0] random_start();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 70) begin
            return 32'd0;
        end else if (roll < 90) begin
            return 32'($urandom_range(0, 8));
        end else if (roll < 95) begin
            return 32'hFFFF_FFFF;
        end
        return $urandom;
    endfunction

    // a region is filler, a planted pattern instance and more filler;
    // some regions are plain noise, some instances carry a broken byte
    task automatic build_region(input int len, input bit single_byte);
        int    n;
        int    i;
        int    e;
        bit    stop;
        t_kind k;
        region_q.delete();
        if (single_byte) begin
            region_q.push_back(pick_byte(len));
            return;
        end
        if ($urandom_range(0, 99) < 70) begin
            n = $urandom_range(0, 6);
            for (i = 0; i < n; i++) begin
                region_q.push_back(pick_byte(len));
            end
            stop = 1'b0;
            for (e = 0; e < len && !stop; e++) begin
                k = t_kind'(p_kinds[2*e +: 2]);
                case (k)
                    K_SPECIFIC: begin
                        if ($urandom_range(0, 99) < 8) begin
                            region_q.push_back(8'($urandom));
                        end else begin
                            region_q.push_back((e < 8) ? p_lo[8*e +: 8]
                                                       : p_hi[8*(e-8) +: 8]);
                        end
                    end
                    K_ANY: begin
                        region_q.push_back(8'($urandom));
                    end
                    K_OPTIONAL: begin
                        if ($urandom_range(0, 1) == 1) begin
                            region_q.push_back(8'($urandom));
                        end
                    end
                    default: begin
                        region_q.push_back(8'($urandom));
                        stop = 1'b1;
                    end
                endcase
            end
            n = $urandom_range(0, len);
            for (i = 0; i < n; i++) begin
                region_q.push_back(pick_byte(len));
            end
            if (region_q.size() == 0) begin
                region_q.push_back(pick_byte(len));
            end
        end else begin
            n = $urandom_range(1, 24);
            for (i = 0; i < n; i++) begin
                region_q.push_back(8'($urandom));
            end
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          r;
        int          i;
        int          n;
        int          len;
        int          phase;
        int          phase_items;
        int          rand_items;
        logic [63:0] lo;
        logic [63:0] hi;
        logic [31:0] kinds;
        logic [4:0]  plen;
        logic [31:0] start;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_BYTES_LO;
        cfg_data  <= '0;
        row_tag   <= ROW_PREDICT;
        row_res   <= '0;
        calm      <= 1'b0;
        hold_ask  <= 0;
        p_lo      = '0;
        p_hi      = '0;
        p_kinds   = '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting: one specific byte of zero, start at zero
        add_byte(ROW_ONE,  8'h00, 1'b0, 1'b1, 32'd0);
        add_byte(ROW_NONE, 8'hFF, 1'b0, 1'b0, 32'd0);
        add_byte(ROW_NONE, 8'h7F, 1'b1, 1'b0, 32'd0);    // after a match, last is quiet
        add_byte(ROW_ONE,  8'hFF, 1'b1, 1'b0, 32'd0);    // one-byte region, not found
        // length zero acts as one
        add_cfg(64'h0000_0000_0000_00AB, 64'd0, 32'(K_SPECIFIC), 5'd0, 32'd0);
        add_byte(ROW_NONE, 8'h00, 1'b0, 1'b0, 32'd0);
        add_byte(ROW_ONE,  8'hAB, 1'b1, 1'b1, 32'd1);
        // all ones, length clipped to the window, region too short
        add_cfg({64{1'b1}}, {64{1'b1}}, {16{K_ANY}}, 5'd31, 32'hFFFF_FFFF);
        add_byte(ROW_NONE, 8'h01, 1'b0, 1'b0, 32'd0);
        add_byte(ROW_NONE, 8'h80, 1'b0, 1'b0, 32'd0);
        add_byte(ROW_ONE,  8'h55, 1'b1, 1'b0, 32'd0);
        // specific, optional, specific, accept rest with a start past zero
        add_cfg(64'h0000_0000_9934_5512, 64'd0,
                32'({K_ACCEPT, K_SPECIFIC, K_OPTIONAL, K_SPECIFIC}), 5'd4, 32'd1);
        add_byte(ROW_PREDICT, 8'h12, 1'b0, 1'b0, 32'd0);
        add_byte(ROW_PREDICT, 8'h34, 1'b0, 1'b0, 32'd0);
        add_byte(ROW_PREDICT, 8'h56, 1'b0, 1'b0, 32'd0);
        add_byte(ROW_PREDICT, 8'h12, 1'b0, 1'b0, 32'd0);
        add_byte(ROW_PREDICT, 8'h99, 1'b0, 1'b0, 32'd0);
        add_byte(ROW_PREDICT, 8'h34, 1'b0, 1'b0, 32'd0);
        add_byte(ROW_PREDICT, 8'hAA, 1'b0, 1'b0, 32'd0);
        add_byte(ROW_PREDICT, 8'hBB, 1'b1, 1'b0, 32'd0);
        // optional last element needs no byte
        add_cfg(64'd0, 64'd0, 32'({K_OPTIONAL, K_ANY}), 5'd2, 32'd0);
        add_byte(ROW_PREDICT, 8'h00, 1'b0, 1'b0, 32'd0);
        add_byte(ROW_PREDICT, 8'hFF, 1'b1, 1'b0, 32'd0);
        // specific last element that misses
        add_cfg(64'h0000_0000_0000_C300, 64'd0, 32'({K_SPECIFIC, K_ANY}), 5'd2, 32'd0);
        add_byte(ROW_PREDICT, 8'hC3, 1'b0, 1'b0, 32'd0);
        add_byte(ROW_PREDICT, 8'h00, 1'b1, 1'b0, 32'd0);

        for (r = 0; r < plan.size(); r++) begin
            if (plan[r].kind == ROW_CFG) begin
                settle();
                load_pattern(plan[r].lo, plan[r].hi, plan[r].kinds, plan[r].len,
                             plan[r].start);
            end else begin
                offer_byte(plan[r].data, plan[r].is_last, plan[r].kind, plan[r].res);
            end
        end

        // random phases, each under its own pattern setting
        phase      = 0;
        rand_items = 0;
        while (rand_items < RAND_ITEMS) begin
            lo    = {$urandom, $urandom};
            hi    = {$urandom, $urandom};
            kinds = random_kinds();
            plen  = random_len();
            start = random_start();
            case (phase)
                0: begin
                    // every register at its top value
                    lo    = {64{1'b1}};
                    hi    = {64{1'b1}};
                    kinds = {32{1'b1}};
                    plen  = 5'd31;
                    start = 32'hFFFF_FFFF;
                end
                1: begin
                    // every register at zero
                    lo    = '0;
                    hi    = '0;
                    kinds = '0;
                    plen  = 5'd0;
                    start = '0;
                end
                2: begin
                    // every byte is its own region and matches: one word each
                    kinds = {16{K_ANY}};
                    plen  = 5'd1;
                    start = '0;
                end
                default: ;
            endcase
            settle();
            load_pattern(lo, hi, kinds, plen, start);
            calm <= (phase == 3);
            if (phase == 2) begin
                hold_ask <= hold_ask + 1;
            end
            len         = active_len(plen);
            phase_items = 0;
            while (phase_items < PHASE_ITEMS) begin
                build_region(len, phase == 2);
                n = region_q.size();
                for (i = 0; i < n; i++) begin
                    offer_byte(region_q[i], i == n - 1, ROW_PREDICT, '0);
                end
                phase_items += n;
            end
            rand_items += phase_items;
            phase++;
        end

        // drain, then a tail for any stray word
        in_valid <= 1'b0;
        calm     <= 1'b0;
        n = 0;
        while (want_words.size() != 0 && n < DRAIN_LIMIT) begin
            @(posedge clk);
            n++;
        end
        repeat (SETTLE) @(posedge clk);
        if (want_words.size() != 0) begin
            report_mismatch($sformatf("%0d expected words never arrived", want_words.size()));
        end
        if (err_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial begin : watchdog
        #25_000_000;
        $display("FAIL");
        $finish;
    end

endmodule

/* files.f */
src/wbs_pkg.sv
src/wbs_window.sv
src/wbs_matcher.sv
src/wildcard_byte_signature_scan.sv
sim/wildcard_byte_signature_scan_tb.sv
